@@ sv/thvs_pkg.sv @@
// shared types, constants and register codes of the heat and vibration sequencer
package thvs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;
  localparam int DUR_W      = 27;
  localparam int TEMP_W     = 12;
  localparam int HUM_W      = 10;
  localparam int ADC_W      = 12;
  localparam int TIME_W     = 32;
  localparam int TSEC_W     = 18;
  localparam int BATX_W     = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_HUMID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DUR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_DUR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TGT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TGT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_TGT   = 3'd7;

  // register reset values
  localparam logic signed [TEMP_W-1:0] RST_OVER_TEMP  = 12'sd420;
  localparam logic [HUM_W-1:0]         RST_OVER_HUMID = 10'd750;
  localparam logic [DUR_W-1:0]         RST_FIRST_DUR  = 27'd660000;
  localparam logic [DUR_W-1:0]         RST_SECOND_DUR = 27'd660000;
  localparam logic [DUR_W-1:0]         RST_THIRD_DUR  = 27'd480000;
  localparam logic signed [TEMP_W-1:0] RST_FIRST_TGT  = 12'sd340;
  localparam logic signed [TEMP_W-1:0] RST_SECOND_TGT = 12'sd360;
  localparam logic signed [TEMP_W-1:0] RST_THIRD_TGT  = 12'sd380;

  // levels
  localparam logic [1:0] LVL_IDLE  = 2'd0;
  localparam logic [1:0] LVL_ONE   = 2'd1;
  localparam logic [1:0] LVL_TWO   = 2'd2;
  localparam logic [1:0] LVL_THREE = 2'd3;

  localparam logic [7:0] DUTY_ONE   = 8'd127;
  localparam logic [7:0] DUTY_TWO   = 8'd191;
  localparam logic [7:0] DUTY_THREE = 8'd255;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_MANUAL     = 3'd1,
    CAUSE_OVER_TEMP  = 3'd2,
    CAUSE_OVER_HUMID = 3'd3,
    CAUSE_FINISHED   = 3'd4
  } cause_t;

  // battery: 110*adc - 204750 over 819, clamped at 100
  localparam logic [18:0]       BAT_OFFSET = 19'd204750;
  localparam logic [18:0]       BAT_SAT    = 19'd82719;
  localparam logic [6:0]        BAT_FULL   = 7'd100;
  localparam logic [17:0]       BAT_RECIP  = 18'd163881;
  localparam int                BAT_SHIFT  = 27;

  // ms to whole seconds, then seconds to minutes
  localparam logic [27:0] SEC_RECIP = 28'd137438954;
  localparam int          SEC_SHIFT = 37;
  localparam logic [18:0] MIN_RECIP = 19'd279621;
  localparam int          MIN_SHIFT = 24;
  localparam logic [11:0] MIN_MAX   = 12'd2047;

  typedef struct packed {
    logic signed [TEMP_W-1:0] over_temp_limit;
    logic [HUM_W-1:0]         over_humid_limit;
    logic [DUR_W-1:0]         first_duration;
    logic [DUR_W-1:0]         second_duration;
    logic [DUR_W-1:0]         third_duration;
    logic signed [TEMP_W-1:0] first_target;
    logic signed [TEMP_W-1:0] second_target;
    logic signed [TEMP_W-1:0] third_target;
  } cfg_t;

  typedef struct packed {
    logic                     switch_on;
    logic signed [TEMP_W-1:0] temperature_dc;
    logic [HUM_W-1:0]         humidity_dpct;
    logic [ADC_W-1:0]         battery_adc;
    logic [TIME_W-1:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic                     active;
    logic [1:0]               level;
    logic [7:0]               vibration_duty;
    logic                     heater_on;
    logic signed [TEMP_W-1:0] target_temp;
    cause_t                   shutdown_cause;
  } run_info_t;

  typedef struct packed {
    run_info_t         info;
    logic [DUR_W-1:0]  rem_ms;
    logic [BATX_W-1:0] bat_x;
    logic              bat_sat;
  } step_t;

  typedef struct packed {
    run_info_t         info;
    logic [TSEC_W-1:0] rem_sec;
    logic [6:0]        battery_percent;
  } scale_t;

  typedef struct packed {
    run_info_t  info;
    logic [10:0] remaining_minutes;
    logic [5:0]  remaining_seconds;
    logic [6:0]  battery_percent;
  } out_item_t;

endpackage

@@ sv/thvs_in_if.sv @@
// tick request channel of the sequencer
interface thvs_in_if;
  logic               valid;
  logic               ready;
  logic               switch_on;
  logic signed [11:0] temperature_dc;
  logic [9:0]         humidity_dpct;
  logic [11:0]        battery_adc;
  logic [31:0]        now_ms;

  modport source (
    output valid, switch_on, temperature_dc, humidity_dpct, battery_adc, now_ms,
    input  ready
  );
  modport sink (
    input  valid, switch_on, temperature_dc, humidity_dpct, battery_adc, now_ms,
    output ready
  );
endinterface

@@ sv/thvs_out_if.sv @@
// result request channel of the sequencer
interface thvs_out_if;
  logic               valid;
  logic               ready;
  logic               active;
  logic [1:0]         level;
  logic [7:0]         vibration_duty;
  logic               heater_on;
  logic signed [11:0] target_temp;
  logic [2:0]         shutdown_cause;
  logic [10:0]        remaining_minutes;
  logic [5:0]         remaining_seconds;
  logic [6:0]         battery_percent;

  modport source (
    output valid, active, level, vibration_duty, heater_on, target_temp,
           shutdown_cause, remaining_minutes, remaining_seconds, battery_percent,
    input  ready
  );
  modport sink (
    input  valid, active, level, vibration_duty, heater_on, target_temp,
           shutdown_cause, remaining_minutes, remaining_seconds, battery_percent,
    output ready
  );
endinterface

@@ sv/thvs_step.sv @@
// run state, level sequencing, safety checks, remaining time in ms and the battery term
module thvs_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                item_vld,
  input  thvs_pkg::in_item_t  item,
  input  thvs_pkg::cfg_t      cfg,
  output thvs_pkg::step_t     step_r
);
  import thvs_pkg::*;

  logic              running_r, running_nxt;
  logic              wait_r, wait_nxt;
  logic [1:0]        stage_r, stage_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  step_t             step_nxt;

  logic [TIME_W-1:0] elapsed;
  logic              restarted;
  cause_t            cause;
  logic [DUR_W-1:0]  dur;
  logic [TIME_W-1:0] rem32;
  logic [18:0]       bat_num;
  logic [18:0]       bat_d;

  always_comb begin
    running_nxt = running_r;
    wait_nxt    = wait_r;
    stage_nxt   = stage_r;
    start_nxt   = start_r;
    cause       = CAUSE_NONE;
    restarted   = 1'b0;

    if (item.switch_on) begin
      if (!running_r && !wait_r) begin
        running_nxt = 1'b1;
        stage_nxt   = LVL_ONE;
        start_nxt   = item.now_ms;
        restarted   = 1'b1;
      end
    end else begin
      wait_nxt = 1'b0;
      if (running_r) begin
        running_nxt = 1'b0;
        stage_nxt   = LVL_IDLE;
        cause       = CAUSE_MANUAL;
      end
    end

    elapsed = item.now_ms - start_nxt;

    if (running_nxt) begin
      if (item.temperature_dc > cfg.over_temp_limit) begin
        cause = CAUSE_OVER_TEMP;
      end else if (item.humidity_dpct > cfg.over_humid_limit) begin
        cause = CAUSE_OVER_HUMID;
      end else if (stage_nxt == LVL_ONE &&
                   elapsed >= TIME_W'(cfg.first_duration)) begin
        stage_nxt = LVL_TWO;
        start_nxt = item.now_ms;
        restarted = 1'b1;
      end else if (stage_nxt == LVL_TWO &&
                   elapsed >= TIME_W'(cfg.second_duration)) begin
        stage_nxt = LVL_THREE;
        start_nxt = item.now_ms;
        restarted = 1'b1;
      end else if (stage_nxt == LVL_THREE &&
                   elapsed >= TIME_W'(cfg.third_duration)) begin
        cause = CAUSE_FINISHED;
      end
      if (cause != CAUSE_NONE) begin
        running_nxt = 1'b0;
        stage_nxt   = LVL_IDLE;
        wait_nxt    = 1'b1;
      end
    end
  end

  // per-level selection
  always_comb begin
    step_nxt = '0;
    step_nxt.info.active         = running_nxt;
    step_nxt.info.shutdown_cause = cause;
    dur = cfg.third_duration;
    unique case (stage_nxt)
      LVL_ONE: begin
        dur                          = cfg.first_duration;
        step_nxt.info.vibration_duty = DUTY_ONE;
        step_nxt.info.target_temp    = cfg.first_target;
      end
      LVL_TWO: begin
        dur                          = cfg.second_duration;
        step_nxt.info.vibration_duty = DUTY_TWO;
        step_nxt.info.target_temp    = cfg.second_target;
      end
      LVL_THREE: begin
        dur                          = cfg.third_duration;
        step_nxt.info.vibration_duty = DUTY_THREE;
        step_nxt.info.target_temp    = cfg.third_target;
      end
      default: begin
        step_nxt.info.vibration_duty = '0;
        step_nxt.info.target_temp    = '0;
      end
    endcase
    // a level still running has at most its duration left, so 27 bits suffice
    rem32 = TIME_W'(dur) - (restarted ? '0 : elapsed);
    if (running_nxt) begin
      step_nxt.info.level     = stage_nxt;
      step_nxt.info.heater_on = item.temperature_dc < step_nxt.info.target_temp;
      step_nxt.rem_ms         = rem32[DUR_W-1:0];
    end else begin
      step_nxt.info.vibration_duty = '0;
      step_nxt.info.target_temp    = '0;
    end

    // 110 * adc as shifts
    bat_num = {item.battery_adc, 7'b0}
              - {3'b0, item.battery_adc, 4'b0}
              - {6'b0, item.battery_adc, 1'b0};
    bat_d = bat_num - BAT_OFFSET;
    if (bat_num > BAT_OFFSET) begin
      step_nxt.bat_sat = bat_d >= BAT_SAT;
      step_nxt.bat_x   = bat_d[BATX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      wait_r    <= 1'b0;
      stage_r   <= LVL_IDLE;
      start_r   <= '0;
    end else if (en && item_vld) begin
      running_r <= running_nxt;
      wait_r    <= wait_nxt;
      stage_r   <= stage_nxt;
      start_r   <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ sv/thvs_scale.sv @@
// reciprocal multiplies: ms to whole seconds and battery percentage
module thvs_scale (
  input  logic             clk,
  input  logic             en,
  input  thvs_pkg::step_t  step,
  output thvs_pkg::scale_t scale_r
);
  import thvs_pkg::*;

  logic [54:0] sec_prod;
  logic [34:0] bat_prod;
  scale_t      scale_nxt;

  assign sec_prod = 55'(step.rem_ms) * 55'(SEC_RECIP);
  assign bat_prod = 35'(step.bat_x) * 35'(BAT_RECIP);

  always_comb begin
    scale_nxt.info    = step.info;
    scale_nxt.rem_sec = sec_prod[SEC_SHIFT +: TSEC_W];
    scale_nxt.battery_percent = step.bat_sat ? BAT_FULL : bat_prod[BAT_SHIFT +: 7];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scale_r <= scale_nxt;
    end
  end

endmodule

@@ sv/thvs_clock.sv @@
// splits remaining seconds into minutes and seconds, result register
module thvs_clock (
  input  logic                clk,
  input  logic                en,
  input  thvs_pkg::scale_t    scale,
  output thvs_pkg::out_item_t res_r
);
  import thvs_pkg::*;

  logic [36:0]       min_prod;
  logic [11:0]       mins;
  logic [TSEC_W-1:0] mins60;
  logic [TSEC_W-1:0] secs;
  out_item_t         res_nxt;

  assign min_prod = 37'(scale.rem_sec) * 37'(MIN_RECIP);
  assign mins     = min_prod[MIN_SHIFT +: 12];
  // 60 * mins as 64 - 4
  assign mins60   = {mins, 6'b0} - {4'b0, mins, 2'b0};
  assign secs     = scale.rem_sec - mins60;

  always_comb begin
    res_nxt.info              = scale.info;
    res_nxt.remaining_minutes = (mins > MIN_MAX) ? MIN_MAX[10:0] : mins[10:0];
    res_nxt.remaining_seconds = secs[5:0];
    res_nxt.battery_percent   = scale.battery_percent;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ sv/timed_heat_vibration_sequencer.sv @@
// top level: a tick request's result is valid once it has passed the whole pipeline
// throughput one request per cycle while not stalled; input register, step, scale, result register
// a stalled result holds the whole pipeline; the run state updates once per request
// synchronous active-low reset clears run state and valid flags and restores
// every configuration register to its default
module timed_heat_vibration_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  thvs_in_if.sink                           in_ch,
  thvs_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [thvs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [thvs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import thvs_pkg::*;

  cfg_t      cfg_r;
  in_item_t  item_r;
  logic      v0_r, v1_r, v2_r, out_valid_r;
  logic      en;
  step_t     step_q;
  scale_t    scale_q;
  out_item_t res_q;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.over_temp_limit  <= RST_OVER_TEMP;
      cfg_r.over_humid_limit <= RST_OVER_HUMID;
      cfg_r.first_duration   <= RST_FIRST_DUR;
      cfg_r.second_duration  <= RST_SECOND_DUR;
      cfg_r.third_duration   <= RST_THIRD_DUR;
      cfg_r.first_target     <= RST_FIRST_TGT;
      cfg_r.second_target    <= RST_SECOND_TGT;
      cfg_r.third_target     <= RST_THIRD_TGT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OVER_TEMP:  cfg_r.over_temp_limit  <= cfg_data[TEMP_W-1:0];
        CFG_OVER_HUMID: cfg_r.over_humid_limit <= cfg_data[HUM_W-1:0];
        CFG_FIRST_DUR:  cfg_r.first_duration   <= cfg_data[DUR_W-1:0];
        CFG_SECOND_DUR: cfg_r.second_duration  <= cfg_data[DUR_W-1:0];
        CFG_THIRD_DUR:  cfg_r.third_duration   <= cfg_data[DUR_W-1:0];
        CFG_FIRST_TGT:  cfg_r.first_target     <= cfg_data[TEMP_W-1:0];
        CFG_SECOND_TGT: cfg_r.second_target    <= cfg_data[TEMP_W-1:0];
        CFG_THIRD_TGT:  cfg_r.third_target     <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_ch.valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r.switch_on      <= in_ch.switch_on;
      item_r.temperature_dc <= in_ch.temperature_dc;
      item_r.humidity_dpct  <= in_ch.humidity_dpct;
      item_r.battery_adc    <= in_ch.battery_adc;
      item_r.now_ms         <= in_ch.now_ms;
    end
  end

  thvs_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .item_vld (v0_r),
    .item     (item_r),
    .cfg      (cfg_r),
    .step_r   (step_q)
  );

  thvs_scale u_scale (
    .clk     (clk),
    .en      (en),
    .step    (step_q),
    .scale_r (scale_q)
  );

  thvs_clock u_clock (
    .clk   (clk),
    .en    (en),
    .scale (scale_q),
    .res_r (res_q)
  );

  assign out_ch.valid             = out_valid_r;
  assign out_ch.active            = res_q.info.active;
  assign out_ch.level             = res_q.info.level;
  assign out_ch.vibration_duty    = res_q.info.vibration_duty;
  assign out_ch.heater_on         = res_q.info.heater_on;
  assign out_ch.target_temp       = res_q.info.target_temp;
  assign out_ch.shutdown_cause    = res_q.info.shutdown_cause;
  assign out_ch.remaining_minutes = res_q.remaining_minutes;
  assign out_ch.remaining_seconds = res_q.remaining_seconds;
  assign out_ch.battery_percent   = res_q.battery_percent;

endmodule

@@ tb/tb_top.sv @@
// self-checking bench for the timed heat and vibration sequencer
module tb_top;
  import thvs_pkg::*;

  localparam int MS_PER_MIN   = 60000;
  localparam int MS_PER_SEC   = 1000;
  localparam int MINUTES_CAP  = 2047;
  localparam int BAT_GAIN     = 110;
  localparam int BAT_ZERO     = 204750;
  localparam int BAT_DIV      = 819;
  localparam int PCT_FULL     = 100;
  localparam int TEMP_LO      = -400;
  localparam int TEMP_SPAN    = 1650;
  localparam int HUMID_TOP    = 1000;
  localparam int IDLE_PCT     = 29;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  thvs_in_if  in_ch ();
  thvs_out_if out_ch ();

  timed_heat_vibration_sequencer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the sequencer: settings and run state
  cfg_t regs = '{over_temp_limit: RST_OVER_TEMP, over_humid_limit: RST_OVER_HUMID,
                 first_duration: RST_FIRST_DUR, second_duration: RST_SECOND_DUR,
                 third_duration: RST_THIRD_DUR, first_target: RST_FIRST_TGT,
                 second_target: RST_SECOND_TGT, third_target: RST_THIRD_TGT};
  logic        run_q = 1'b0;
  logic        release_wait = 1'b0;
  logic [1:0]  lvl_q = LVL_IDLE;
  logic [31:0] lvl_start = '0;

  in_item_t  ticks_to_send[$];
  out_item_t expected_status[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        hold_left = 0;
  bit        no_gaps = 1'b0;
  int        tick_step = 1000;
  logic [31:0] clock_ms = '0;

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.switch_on      = 1'b0;
    in_ch.temperature_dc = '0;
    in_ch.humidity_dpct  = '0;
    in_ch.battery_adc    = '0;
    in_ch.now_ms         = '0;
    out_ch.ready         = 1'b0;
  end

  function automatic out_item_t advance_sequencer(in_item_t tk);
    out_item_t          o;
    cause_t             cause;
    logic [31:0]        elapsed;
    logic [31:0]        dur;
    logic [31:0]        rem;
    logic [31:0]        mins;
    logic signed [11:0] tgt;
    int                 bat;
    o = '0;
    cause = CAUSE_NONE;
    if (tk.switch_on) begin
      if (!run_q && !release_wait) begin
        run_q = 1'b1;
        lvl_q = LVL_ONE;
        lvl_start = tk.now_ms;
      end
    end else begin
      release_wait = 1'b0;
      if (run_q) begin
        run_q = 1'b0;
        lvl_q = LVL_IDLE;
        cause = CAUSE_MANUAL;
      end
    end
    if (run_q) begin
      elapsed = tk.now_ms - lvl_start;
      // safety first, then at most one level step per tick
      if ($signed(tk.temperature_dc) > $signed(regs.over_temp_limit)) begin
        cause = CAUSE_OVER_TEMP;
      end else if (tk.humidity_dpct > regs.over_humid_limit) begin
        cause = CAUSE_OVER_HUMID;
      end else if (lvl_q == LVL_ONE && elapsed >= 32'(regs.first_duration)) begin
        lvl_q = LVL_TWO;
        lvl_start = tk.now_ms;
      end else if (lvl_q == LVL_TWO && elapsed >= 32'(regs.second_duration)) begin
        lvl_q = LVL_THREE;
        lvl_start = tk.now_ms;
      end else if (lvl_q == LVL_THREE && elapsed >= 32'(regs.third_duration)) begin
        cause = CAUSE_FINISHED;
      end
      if (cause != CAUSE_NONE) begin
        run_q = 1'b0;
        lvl_q = LVL_IDLE;
        release_wait = 1'b1;
      end
    end
    if (run_q) begin
      case (lvl_q)
        LVL_ONE: begin
          dur = 32'(regs.first_duration);
          tgt = regs.first_target;
          o.info.vibration_duty = DUTY_ONE;
        end
        LVL_TWO: begin
          dur = 32'(regs.second_duration);
          tgt = regs.second_target;
          o.info.vibration_duty = DUTY_TWO;
        end
        default: begin
          dur = 32'(regs.third_duration);
          tgt = regs.third_target;
          o.info.vibration_duty = DUTY_THREE;
        end
      endcase
      rem = dur - (tk.now_ms - lvl_start);
      mins = rem / MS_PER_MIN;
      o.info.active = 1'b1;
      o.info.level = lvl_q;
      o.info.heater_on = $signed(tk.temperature_dc) < tgt;
      o.info.target_temp = tgt;
      o.remaining_minutes = (mins > MINUTES_CAP) ? 11'(MINUTES_CAP) : mins[10:0];
      o.remaining_seconds = 6'((rem % MS_PER_MIN) / MS_PER_SEC);
    end
    o.info.shutdown_cause = cause;
    bat = BAT_GAIN * int'(tk.battery_adc);
    if (bat <= BAT_ZERO) begin
      o.battery_percent = '0;
    end else begin
      bat = (bat - BAT_ZERO) / BAT_DIV;
      o.battery_percent = 7'((bat > PCT_FULL) ? PCT_FULL : bat);
    end
    return o;
  endfunction

  function automatic string describe(out_item_t o);
    return $sformatf("act=%0b lvl=%0d duty=%0d heat=%0b tgt=%0d cause=%0d min=%0d sec=%0d bat=%0d",
                     o.info.active, o.info.level, o.info.vibration_duty, o.info.heater_on,
                     $signed(o.info.target_temp), o.info.shutdown_cause,
                     o.remaining_minutes, o.remaining_seconds, o.battery_percent);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
  endtask

  // tick driver: holds a request until taken, otherwise may idle
  always @(posedge clk) begin
    in_item_t tk;
    logic     offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tk.switch_on      = in_ch.switch_on;
        tk.temperature_dc = in_ch.temperature_dc;
        tk.humidity_dpct  = in_ch.humidity_dpct;
        tk.battery_adc    = in_ch.battery_adc;
        tk.now_ms         = in_ch.now_ms;
        expected_status.push_back(advance_sequencer(tk));
        void'(ticks_to_send.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        offer = 1'b1;
      end else begin
        offer = ticks_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT);
      end
      in_ch.valid <= offer;
      if (offer) begin
        tk = ticks_to_send[0];
        in_ch.switch_on      <= tk.switch_on;
        in_ch.temperature_dc <= tk.temperature_dc;
        in_ch.humidity_dpct  <= tk.humidity_dpct;
        in_ch.battery_adc    <= tk.battery_adc;
        in_ch.now_ms         <= tk.now_ms;
      end
    end
  end

  // status monitor and checker
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.info.active         = out_ch.active;
        got.info.level          = out_ch.level;
        got.info.vibration_duty = out_ch.vibration_duty;
        got.info.heater_on      = out_ch.heater_on;
        got.info.target_temp    = out_ch.target_temp;
        got.info.shutdown_cause = cause_t'(out_ch.shutdown_cause);
        got.remaining_minutes   = out_ch.remaining_minutes;
        got.remaining_seconds   = out_ch.remaining_seconds;
        got.battery_percent     = out_ch.battery_percent;
        if (expected_status.size() == 0) begin
          note_mismatch($sformatf("result %0d with nothing expected: %s",
                                  results_seen, describe(got)));
        end else begin
          want = expected_status.pop_front();
          bad = (got.info.active !== want.info.active)
             || (got.info.level !== want.info.level)
             || (got.info.vibration_duty !== want.info.vibration_duty)
             || (got.info.heater_on !== want.info.heater_on)
             || (got.info.target_temp !== want.info.target_temp)
             || (got.info.shutdown_cause !== want.info.shutdown_cause)
             || (got.remaining_minutes !== want.remaining_minutes)
             || (got.remaining_seconds !== want.remaining_seconds)
             || (got.battery_percent !== want.battery_percent);
          if (bad) begin
            note_mismatch($sformatf("result %0d expected %s got %s",
                                    results_seen, describe(want), describe(got)));
          end
        end
        // one long back-pressure stretch so the pipeline fills
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  task automatic add_tick(logic sw, logic [11:0] temp, logic [9:0] hum, logic [11:0] adc,
                          logic [31:0] ms);
    in_item_t tk;
    tk.switch_on      = sw;
    tk.temperature_dc = temp;
    tk.humidity_dpct  = hum;
    tk.battery_adc    = adc;
    tk.now_ms         = ms;
    ticks_to_send.push_back(tk);
  endtask

  // sessions of switch-on ticks with plausible readings, broken up by a few off ticks
  task automatic send_random_ticks(int n);
    in_item_t tk;
    int       hi;
    int       r;
    int       on_left;
    on_left = $urandom_range(1, 30);
    for (int i = 0; i < n; i++) begin
      tk.switch_on = (on_left != 0);
      if (on_left == 0) begin
        on_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 30);
      end else begin
        on_left--;
      end
      hi = $signed(regs.over_temp_limit);
      r = $urandom_range(99);
      if (r < 3) begin
        tk.temperature_dc = 12'(hi + 1);
      end else if (r < 6) begin
        tk.temperature_dc = 12'(hi);
      end else if (r < 9 || hi < TEMP_LO) begin
        tk.temperature_dc = 12'($urandom);
      end else begin
        tk.temperature_dc = 12'(TEMP_LO + int'($urandom_range(hi - TEMP_LO)));
      end
      r = $urandom_range(99);
      if (r < 2) begin
        tk.humidity_dpct = 10'(regs.over_humid_limit + 1);
      end else if (r < 5) begin
        tk.humidity_dpct = 10'($urandom);
      end else begin
        tk.humidity_dpct = 10'($urandom_range(regs.over_humid_limit));
      end
      tk.battery_adc = 12'($urandom);
      r = $urandom_range(99);
      if (r < 4) begin
        clock_ms = $urandom;
      end else if (r >= 8) begin
        clock_ms += $urandom_range(tick_step);
      end
      // otherwise the millisecond clock stands still
      tk.now_ms = clock_ms;
      ticks_to_send.push_back(tk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_OVER_TEMP:  regs.over_temp_limit  = data[TEMP_W-1:0];
      CFG_OVER_HUMID: regs.over_humid_limit = data[HUM_W-1:0];
      CFG_FIRST_DUR:  regs.first_duration   = data[DUR_W-1:0];
      CFG_SECOND_DUR: regs.second_duration  = data[DUR_W-1:0];
      CFG_THIRD_DUR:  regs.third_duration   = data[DUR_W-1:0];
      CFG_FIRST_TGT:  regs.first_target     = data[TEMP_W-1:0];
      CFG_SECOND_TGT: regs.second_target    = data[TEMP_W-1:0];
      CFG_THIRD_TGT:  regs.third_target     = data[TEMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [11:0] ot, logic [9:0] oh, logic [26:0] d1,
                               logic [26:0] d2, logic [26:0] d3, logic [11:0] t1,
                               logic [11:0] t2, logic [11:0] t3);
    write_reg(CFG_OVER_TEMP, 27'(ot));
    write_reg(CFG_OVER_HUMID, 27'(oh));
    write_reg(CFG_FIRST_DUR, d1);
    write_reg(CFG_SECOND_DUR, d2);
    write_reg(CFG_THIRD_DUR, d3);
    write_reg(CFG_FIRST_TGT, 27'(t1));
    write_reg(CFG_SECOND_TGT, 27'(t2));
    write_reg(CFG_THIRD_TGT, 27'(t3));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (ticks_to_send.size() != 0 || expected_status.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit wide;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings: all three levels, boundaries, manual, over-temperature and over-humidity shutdowns, clock wrap
    add_tick(1'b0, 12'd0, 10'd0, 12'd0, 32'd0);
    add_tick(1'b1, 12'd200, 10'd500, 12'd4095, 32'd1000);
    add_tick(1'b1, 12'd340, 10'd750, 12'd1861, 32'd660999);
    add_tick(1'b1, 12'd339, 10'd0, 12'd1862, 32'd661000);
    add_tick(1'b1, 12'd360, 10'd100, 12'd2607, 32'd721500);
    add_tick(1'b1, 12'd420, 10'd100, 12'd3000, 32'd1321000);
    add_tick(1'b1, 12'd379, 10'd100, 12'd3500, 32'd1801000);
    add_tick(1'b1, 12'd0, 10'd0, 12'd3000, 32'd1802000);
    add_tick(1'b0, 12'd0, 10'd0, 12'd3000, 32'd1803000);
    add_tick(1'b1, 12'd421, 10'd0, 12'd3000, 32'd1804000);
    add_tick(1'b0, 12'd0, 10'd0, 12'd2000, 32'd1805000);
    add_tick(1'b1, 12'd420, 10'd751, 12'd2000, 32'd1806000);
    add_tick(1'b0, 12'd0, 10'd0, 12'd2000, 32'd1807000);
    add_tick(1'b1, -12'sd400, 10'd0, 12'd2000, 32'hFFFF_FF00);
    add_tick(1'b1, -12'sd2048, 10'd750, 12'd2000, 32'h0000_0100);
    add_tick(1'b0, 12'sd2047, 10'd1023, 12'd4095, 32'h0000_0200);
    add_tick(1'b1, 12'sd2047, 10'd0, 12'd0, 32'hFFFF_FFFF);
    add_tick(1'b0, -12'sd1, 10'd0, 12'd2048, 32'd0);
    wait_all_results();

    // top limits, levels of zero length, extreme targets
    tick_step = 1000;
    clock_ms = $urandom;
    load_settings(12'h7FF, 10'h3FF, '0, '0, '0, 12'h800, 12'h7FF, 12'h000);
    send_random_ticks(100);
    wait_all_results();

    // bottom limits with the longest levels
    tick_step = 1 << 24;
    load_settings(12'h800, 10'h000, DUR_MAX, DUR_MAX, DUR_MAX, 12'h7FF, 12'h800, 12'hFFF);
    send_random_ticks(40);
    wait_all_results();

    // longest levels with no safety trips, minutes saturate
    tick_step = 1 << 25;
    load_settings(12'h7FF, 10'h3FF, DUR_MAX, DUR_MAX, DUR_MAX,
                  12'(TEMP_LO + int'($urandom_range(TEMP_SPAN))),
                  12'(TEMP_LO + int'($urandom_range(TEMP_SPAN))),
                  12'(TEMP_LO + int'($urandom_range(TEMP_SPAN))));
    send_random_ticks(100);
    wait_all_results();

    for (int p = 0; p < 10; p++) begin
      no_gaps = (p == 4);
      wide = (p == 2 || p == 7);
      tick_step = wide ? (1 << 24) : 3000;
      clock_ms = (p % 3 == 0) ? 32'hFFFF_0000 + $urandom_range(65535) : $urandom;
      load_settings(12'(TEMP_LO + int'($urandom_range(TEMP_SPAN))),
                    10'($urandom_range(HUMID_TOP)),
                    wide ? 27'($urandom) : 27'($urandom_range(1000, 6000)),
                    wide ? 27'($urandom) : 27'($urandom_range(1000, 6000)),
                    wide ? 27'($urandom) : 27'($urandom_range(1000, 6000)),
                    12'(TEMP_LO + int'($urandom_range(TEMP_SPAN))),
                    12'(TEMP_LO + int'($urandom_range(TEMP_SPAN))),
                    12'(TEMP_LO + int'($urandom_range(TEMP_SPAN))));
      send_random_ticks(125);
      wait_all_results();
    end
    no_gaps = 1'b0;

    // let any stray result show up before the verdict
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
